FILE: hw/rtl/cbm_pkg.sv
// shared types and decode constants for the cartridge bank mapper
package cbm_pkg;

  // item kinds
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // write regions on addr[15:12]
  localparam logic [3:0] REGION_LATCH0  = 4'h8;
  localparam logic [3:0] REGION_LATCH1  = 4'h9;
  localparam logic [3:0] REGION_LATCH2  = 4'hA;
  localparam logic [3:0] REGION_LATCH3  = 4'hB;
  localparam logic [3:0] REGION_IRQ_CTL = 4'hC;
  localparam logic [3:0] REGION_IRQ_ACK = 4'hD;
  localparam logic [3:0] REGION_SELECT  = 4'hE;
  localparam logic [3:0] REGION_BANK    = 4'hF;

  // bank region sub-select on addr[11:10]
  localparam logic [1:0] BANK_PRG_HI = 2'd0;
  localparam logic [1:0] BANK_NONE   = 2'd1;
  localparam logic [1:0] BANK_MIRROR = 2'd2;
  localparam logic [1:0] BANK_CHR    = 2'd3;

  localparam logic [15:0] COUNT_WRAP = 16'hFFFF;

  localparam int PRG_REGS = 4;
  localparam int CHR_REGS = 8;

  // one input word
  typedef struct packed {
    logic        mode;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } item_t;

  // one result word
  typedef struct packed {
    logic        irq_line;
    logic [4:0]  prg_bank_first;
    logic [4:0]  prg_bank_second;
    logic [4:0]  prg_bank_third;
    logic [63:0] chr_banks_packed;
    logic        mirror_select;
  } result_t;

endpackage

FILE: hw/rtl/cartridge_bank_mapper_with_irq_counter_top.sv
// Cartridge bank mapper with a CPU-cycle irq counter, top level.
// A word accepted into the input register passes through the state update into the result
// register, which drives out_; out_stall can hold it in the input register before that.
// Throughput: one word per cycle while out_stall is low; the input register and the
// result register each hold one word, and the state update is a single pass between them.
// Reset (rst_n low, synchronous) clears all mapper state and both pipeline valids.
module cartridge_bank_mapper_with_irq_counter_top import cbm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [15:0] in_addr,
  input  logic [7:0]  in_wdata,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_irq_line,
  output logic [4:0]  out_prg_bank_first,
  output logic [4:0]  out_prg_bank_second,
  output logic [4:0]  out_prg_bank_third,
  output logic [63:0] out_chr_banks_packed,
  output logic        out_mirror_select
);

  logic    s1_valid_r, s1_valid_nxt;
  item_t   s1_item_r;
  logic    out_valid_r, out_valid_nxt;
  result_t out_word_r;
  result_t core_result;
  logic    out_free;
  logic    adv;
  logic    accept;

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = accept ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = adv ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r.mode  <= in_mode;
      s1_item_r.addr  <= in_addr;
      s1_item_r.wdata <= in_wdata;
    end
  end

  // mapper state and update
  cbm_state u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (adv),
    .item   (s1_item_r),
    .result (core_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (adv) out_word_r <= core_result;
  end

  assign out_valid            = out_valid_r;
  assign out_irq_line         = out_word_r.irq_line;
  assign out_prg_bank_first   = out_word_r.prg_bank_first;
  assign out_prg_bank_second  = out_word_r.prg_bank_second;
  assign out_prg_bank_third   = out_word_r.prg_bank_third;
  assign out_chr_banks_packed = out_word_r.chr_banks_packed;
  assign out_mirror_select    = out_word_r.mirror_select;

  // stall only while the input register holds a word
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("stall without a held word");

  // a held word that cannot move stays held
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r)
    else $error("word lost from input register");

  // a word that moves forward appears at the output
  a_forward: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced word not presented");

endmodule

FILE: hw/rtl/cbm_state.sv
// mapper register file, irq counter and the single-pass update logic
module cbm_state import cbm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    upd,
  input  item_t   item,
  output result_t result
);

  logic [3:0]  sel_r, sel_nxt;
  logic [4:0]  prg_r [PRG_REGS];
  logic [4:0]  prg_nxt [PRG_REGS];
  logic [7:0]  chr_r [CHR_REGS];
  logic [7:0]  chr_nxt [CHR_REGS];
  logic        mirror_r, mirror_nxt;
  logic [2:0]  en_r, en_nxt;
  logic [15:0] latch_r, latch_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        irq_r, irq_nxt;
  logic [3:0]  sel_m1;
  logic [3:0]  nib;

  assign nib    = item.wdata[3:0];
  assign sel_m1 = sel_r - 4'd1;

  // next state for one item
  always_comb begin
    sel_nxt    = sel_r;
    prg_nxt    = prg_r;
    chr_nxt    = chr_r;
    mirror_nxt = mirror_r;
    en_nxt     = en_r;
    latch_nxt  = latch_r;
    cnt_nxt    = cnt_r;
    irq_nxt    = irq_r;
    if (item.mode == MODE_TICK) begin
      if (en_r[1]) begin
        if (cnt_r == COUNT_WRAP) begin
          cnt_nxt = latch_r;
          irq_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 16'd1;
        end
      end
    end else begin
      case (item.addr[15:12])
        REGION_LATCH0:  latch_nxt[3:0]   = nib;
        REGION_LATCH1:  latch_nxt[7:4]   = nib;
        REGION_LATCH2:  latch_nxt[11:8]  = nib;
        REGION_LATCH3:  latch_nxt[15:12] = nib;
        REGION_IRQ_CTL: begin
          en_nxt  = item.wdata[2:0];
          if (item.wdata[1]) cnt_nxt = latch_r;
          irq_nxt = 1'b0;
        end
        REGION_IRQ_ACK: begin
          en_nxt[1] = en_r[0];
          irq_nxt   = 1'b0;
        end
        REGION_SELECT:  sel_nxt = nib;
        REGION_BANK: begin
          // low nibble of the selected program register
          if (sel_r >= 4'd1 && sel_r <= 4'd4) prg_nxt[sel_m1[1:0]][3:0] = nib;
          case (item.addr[11:10])
            BANK_PRG_HI: prg_nxt[item.addr[1:0]][4] = item.wdata[4];
            BANK_NONE:   ;
            BANK_MIRROR: mirror_nxt = item.wdata[0];
            BANK_CHR:    chr_nxt[item.addr[2:0]] = item.wdata;
            default:     ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // result view of the updated state
  always_comb begin
    result.irq_line        = irq_nxt;
    result.prg_bank_first  = prg_nxt[0];
    result.prg_bank_second = prg_nxt[1];
    result.prg_bank_third  = prg_nxt[2];
    for (int i = 0; i < CHR_REGS; i++) result.chr_banks_packed[8*i +: 8] = chr_nxt[i];
    result.mirror_select   = mirror_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r    <= '0;
      for (int i = 0; i < PRG_REGS; i++) prg_r[i] <= '0;
      for (int i = 0; i < CHR_REGS; i++) chr_r[i] <= '0;
      mirror_r <= 1'b0;
      en_r     <= '0;
      latch_r  <= '0;
      cnt_r    <= '0;
      irq_r    <= 1'b0;
    end else if (upd) begin
      sel_r    <= sel_nxt;
      prg_r    <= prg_nxt;
      chr_r    <= chr_nxt;
      mirror_r <= mirror_nxt;
      en_r     <= en_nxt;
      latch_r  <= latch_nxt;
      cnt_r    <= cnt_nxt;
      irq_r    <= irq_nxt;
    end
  end

  // irq control or ack write always clears the request
  a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
    upd && item.mode == MODE_WRITE &&
    (item.addr[15:12] == REGION_IRQ_CTL || item.addr[15:12] == REGION_IRQ_ACK)
    |=> !irq_r)
    else $error("irq request survived an ack write");

  // a tick while counting is off leaves the counter alone
  a_tick_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    upd && item.mode == MODE_TICK && !en_r[1] |=> $stable(cnt_r))
    else $error("counter moved while disabled");

  // the request only rises on a wrapping tick
  a_irq_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(irq_r) |-> $past(upd && item.mode == MODE_TICK && en_r[1] && cnt_r == COUNT_WRAP))
    else $error("irq raised without counter wrap");

endmodule
